// ----- rtl/frame_rate_window_meter_unit_assert.svh -----
// Assertion macros for the frame rate window meter.
// Included by files that check; relies on clk and arst_n in the including scope.
`ifndef FRAME_RATE_WINDOW_METER_UNIT_ASSERT_SVH
`define FRAME_RATE_WINDOW_METER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FRWM_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frwm assertion failed");
`define FRWM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frwm assertion failed");
`else
`define FRWM_ASSERT_IMPL(name, ante, cons)
`define FRWM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/frwm_pkg.sv -----
// Shared types and constants for the frame rate window meter.
// No dependencies.
package frwm_pkg;

	localparam int TICK_W = 32;
	localparam int FPS_W  = 18;

	// 1000 ms/s scaled by 256 for Q.8
	localparam logic [FPS_W-1:0] FPS_SCALE = 18'd256000;
	localparam logic [FPS_W-1:0] FPS_MAX   = 18'h3FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_DIV,
		ST_FIN
	} frwm_state_t;

	typedef struct packed {
		logic capture;
		logic sub_old;
		logic add_new;
		logic div_step;
		logic finish;
	} frwm_cmd_t;

	typedef struct packed {
		logic out_stall;
	} frwm_status_t;

endpackage

// ----- rtl/frwm_if.sv -----
// Valid/ready channel interfaces for the frame rate window meter.
// Depends on frwm_pkg for field widths.
interface frwm_in_if import frwm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] tick_ms;

	modport source (output valid, output tick_ms, input ready);
	modport sink (input valid, input tick_ms, output ready);
endinterface

interface frwm_out_if import frwm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [FPS_W-1:0] fps_q8;
	logic             zero_time;

	modport source (output valid, output fps_q8, output zero_time, input ready);
	modport sink (input valid, input fps_q8, input zero_time, output ready);
endinterface

// ----- rtl/frwm_ctrl.sv -----
// Sequencer for the frame rate window meter: update, divide, deliver.
// Depends on frwm_pkg.
module frwm_ctrl import frwm_pkg::*; #(
	parameter int NUM_W = 23
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  frwm_status_t stat,
	output frwm_cmd_t    cmd
);

	localparam int STEP_W = $clog2(NUM_W);

	frwm_state_t       state_q;
	frwm_state_t       state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ADD)
				step_q <= STEP_W'(NUM_W - 1);
			else if (state_q == ST_DIV)
				step_q <= step_q - 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.sub_old = 1'b1;
				state_d     = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_new = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register is free
				if (!stat.out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/frwm_dp.sv -----
// Datapath: frame time ring, running sum, restoring divider, output register.
// Depends on frwm_pkg.
module frwm_dp import frwm_pkg::*; #(
	parameter int WINDOW_FRAMES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frwm_cmd_t         cmd,
	output frwm_status_t      stat,
	input  logic [TICK_W-1:0] tick_ms,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [FPS_W-1:0]  fps_q8,
	output logic              zero_time
);

	localparam int SLOT_W = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
	localparam int CNT_W  = $clog2(WINDOW_FRAMES + 1);
	localparam int SUM_W  = TICK_W + $clog2(WINDOW_FRAMES);
	localparam int NUM_W  = FPS_W + CNT_W;

	logic [TICK_W-1:0] ring_mem [WINDOW_FRAMES];
	logic [TICK_W-1:0] rd_old_q;
	logic [TICK_W-1:0] delta_q;
	logic [TICK_W-1:0] last_tick_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  rem_q;
	logic              out_valid_q;
	logic [FPS_W-1:0]  fps_q;
	logic              zero_q;

	logic              full;
	logic [SUM_W:0]    trial;
	logic              fits;
	logic [FPS_W-1:0]  fps_sat;

	assign full    = (count_q == CNT_W'(WINDOW_FRAMES));
	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign fits    = (trial >= {1'b0, sum_q});
	assign fps_sat = (|num_q[NUM_W-1:FPS_W]) ? FPS_MAX : num_q[FPS_W-1:0];

	// ring read is registered; slot is stable from the previous update to SUB
	always_ff @(posedge clk) begin
		rd_old_q <= ring_mem[slot_q];
		if (cmd.sub_old)
			ring_mem[slot_q] <= delta_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
			slot_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture)
				last_tick_q <= tick_ms;
			if (cmd.sub_old) begin
				if (full)
					sum_q <= sum_q - SUM_W'(rd_old_q);
				else
					count_q <= count_q + 1'b1;
				slot_q <= (slot_q == SLOT_W'(WINDOW_FRAMES - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.add_new)
				sum_q <= sum_q + SUM_W'(delta_q);
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			delta_q <= tick_ms - last_tick_q;
		if (cmd.add_new) begin
			num_q <= NUM_W'(FPS_SCALE) * NUM_W'(count_q);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			// one quotient bit per cycle, shifted in where the numerator leaves
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
		end
		if (cmd.finish) begin
			fps_q  <= fps_sat;
			zero_q <= (sum_q == '0);
		end
	end

	assign stat.out_stall = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign fps_q8         = fps_q;
	assign zero_time      = zero_q;

endmodule

// ----- rtl/frame_rate_window_meter_unit.sv -----
// Frame rate window meter: moving average fps over the last WINDOW_FRAMES frames.
// Each transfer in passes SUB, ADD, NUM_W divide steps (NUM_W = 18 + clog2(WINDOW_FRAMES+1),
// 23 at the default) of the one-bit-per-cycle restoring divider and FIN before the result is valid.
// A new item is taken only once the sequencer is back in IDLE; a stalled output holds it in FIN.
// arst_n clears the sequencer, previous tick, slot, count, sum and output valid;
// ring contents are not cleared and are only read once written.
`include "frame_rate_window_meter_unit_assert.svh"
module frame_rate_window_meter_unit import frwm_pkg::*; #(
	parameter int WINDOW_FRAMES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	frwm_in_if.sink      in_ch,
	frwm_out_if.source   out_ch
);

	localparam int NUM_W = FPS_W + $clog2(WINDOW_FRAMES + 1);

	frwm_cmd_t    cmd;
	frwm_status_t stat;
	logic         in_ready;

	frwm_ctrl #(
		.NUM_W(NUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	frwm_dp #(
		.WINDOW_FRAMES(WINDOW_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.tick_ms   (in_ch.tick_ms),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.fps_q8    (out_ch.fps_q8),
		.zero_time (out_ch.zero_time)
	);

	assign in_ch.ready = in_ready;

	`FRWM_ASSERT_NEXT(a_busy_after_transfer, in_ch.valid && in_ch.ready, !in_ch.ready)
	`FRWM_ASSERT_IMPL(a_zero_saturates, out_ch.valid && out_ch.zero_time, out_ch.fps_q8 == FPS_MAX)
	`FRWM_ASSERT_IMPL(a_result_from_finish, $rose(out_ch.valid), $past(cmd.finish))

endmodule

// ----- bench/tb_top.sv -----
// Testbench for frame_rate_window_meter_unit: directed and random frame timestamps,
// checked against a running-window fps predictor. Uses frwm_pkg and the frwm_if channels.
module tb_top;
	import frwm_pkg::*;

	localparam int WINDOW_FRAMES  = 16;
	localparam int DIRECTED_ITEMS = 24;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_AFTER     = 400;
	localparam int HOLD_CYCLES    = 600;

	typedef struct packed {
		logic [FPS_W-1:0] fps_q8;
		logic             zero_time;
	} rate_t;

	typedef enum int {SEG_STEADY, SEG_WIDE, SEG_PAUSE, SEG_FAST, SEG_JUMP, SEG_WRAP} segment_t;
	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BUSY} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	frwm_in_if  in_ch ();
	frwm_out_if out_ch ();

	frame_rate_window_meter_unit #(.WINDOW_FRAMES(WINDOW_FRAMES)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [TICK_W-1:0] frame_ms [WINDOW_FRAMES];
	logic [TICK_W-1:0] prev_tick_ms = '0;
	int unsigned       next_slot = 0;
	int unsigned       frames_seen = 0;
	logic [35:0]       window_total = '0;

	logic [TICK_W-1:0] pending_ticks [$];
	rate_t             expected_rates [$];
	logic [TICK_W-1:0] stim_tick;

	int          failures = 0;
	int          inputs_taken = 0;
	int          idle_cycles = 0;
	logic        in_taken_now = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          stall_left = 0;
	sink_mode_t  stall_mode = SINK_OPEN;

	function automatic rate_t advance_window(input logic [TICK_W-1:0] tick);
		logic [TICK_W-1:0] delta;
		logic [63:0]       quot;
		rate_t             r;
		delta = tick - prev_tick_ms;
		// full ring: oldest frame time drops out of the sum
		if (frames_seen >= WINDOW_FRAMES) begin
			window_total = window_total - frame_ms[next_slot];
		end else begin
			frames_seen++;
		end
		frame_ms[next_slot] = delta;
		window_total = window_total + delta;
		prev_tick_ms = tick;
		next_slot = (next_slot == WINDOW_FRAMES - 1) ? 0 : next_slot + 1;
		if (window_total == 0) begin
			r.fps_q8    = FPS_MAX;
			r.zero_time = 1'b1;
		end else begin
			quot = (64'(FPS_SCALE) * 64'(frames_seen)) / 64'(window_total);
			r.fps_q8    = (quot > 64'(FPS_MAX)) ? FPS_MAX : quot[FPS_W-1:0];
			r.zero_time = 1'b0;
		end
		return r;
	endfunction

	task automatic add_segment(input segment_t kind);
		int                n;
		logic [TICK_W-1:0] step;
		n = (kind == SEG_PAUSE) ? $urandom_range(16, 24) : $urandom_range(8, 48);
		if (kind == SEG_WRAP) begin
			stim_tick = 32'hFFFF_FFFF - $urandom_range(0, 600);
		end
		repeat (n) begin
			case (kind)
				SEG_WIDE:  step = $urandom();
				SEG_PAUSE: step = '0;
				SEG_FAST:  step = $urandom_range(0, 2);
				default:   step = $urandom_range(5, 50);
			endcase
			if (kind == SEG_JUMP) begin
				stim_tick = $urandom();
			end else begin
				stim_tick = stim_tick + step;
			end
			pending_ticks.push_back(stim_tick);
		end
	endtask

	// sender: bursts of random length, random gaps between them
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken_now) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				in_ch.tick_ms <= pending_ticks.pop_front();
				in_ch.valid   <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
				end else begin
					burst_left--;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern is redrawn at random intervals, one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ch.ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = sink_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 300);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				SINK_OPEN:   out_ch.ready <= 1'b1;
				SINK_COIN:   out_ch.ready <= $urandom_range(0, 1);
				SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
				default:     out_ch.ready <= ($urandom_range(0, 5) != 0);
			endcase
		end
	end

	// transfers in feed the predictor; transfers out are checked in order
	always @(posedge clk) begin
		rate_t want;
		in_taken_now <= in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_rates.push_back(advance_window(in_ch.tick_ms));
				inputs_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_rates.size() == 0) begin
					failures++;
					$display("%0t: unexpected result: expected none, actual fps_q8 %0d zero_time %0b",
						$time, out_ch.fps_q8, out_ch.zero_time);
				end else begin
					want = expected_rates.pop_front();
					if (out_ch.fps_q8 !== want.fps_q8) begin
						failures++;
						$display("%0t: fps_q8 mismatch: expected %0d, actual %0d",
							$time, want.fps_q8, out_ch.fps_q8);
					end
					if (out_ch.zero_time !== want.zero_time) begin
						failures++;
						$display("%0t: zero_time mismatch: expected %0b, actual %0b",
							$time, want.zero_time, out_ch.zero_time);
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("frame_rate_window_meter_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		in_ch.valid   = 1'b0;
		in_ch.tick_ms = '0;
		out_ch.ready  = 1'b0;
		arst_n        = 1'b0;

		// first frame and repeated tick give a zero sum; then a one-ms window saturates,
		// huge and wrapping deltas, then enough frames to wrap the ring
		pending_ticks.push_back(32'h0000_0000);
		pending_ticks.push_back(32'h0000_0000);
		pending_ticks.push_back(32'h0000_0001);
		pending_ticks.push_back(32'hFFFF_FFFF);
		pending_ticks.push_back(32'h0000_0010);
		pending_ticks.push_back(32'hAAAA_AAAA);
		pending_ticks.push_back(32'h5555_5555);
		stim_tick = 32'h5555_5555;
		repeat (DIRECTED_ITEMS - 7) begin
			stim_tick = stim_tick + 32'd16;
			pending_ticks.push_back(stim_tick);
		end

		// mostly plausible frame pacing, some pauses, bursts, wraps and noise
		while (pending_ticks.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				5:       add_segment(SEG_WIDE);
				6:       add_segment(SEG_PAUSE);
				7:       add_segment(SEG_FAST);
				8:       add_segment(SEG_JUMP);
				9:       add_segment(SEG_WRAP);
				default: add_segment(SEG_STEADY);
			endcase
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ticks.size() != 0 || in_ch.valid || expected_rates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("frame_rate_window_meter_unit verification clean");
		end else begin
			$display("frame_rate_window_meter_unit verification failed");
		end
		$finish;
	end

endmodule
